// ===== sv/kffc_pkg.sv =====
package kffc_pkg;

   // Widths of the item fields
   localparam int KEY_W    = 5;
   localparam int RES_W    = 35;
   localparam int STATUS_W = 3;
   localparam int OPER_W   = 3;

   // Key codes
   localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 5'd9;
   localparam logic [KEY_W-1:0] KEY_ADD       = 5'd19;
   localparam logic [KEY_W-1:0] KEY_SUB       = 5'd20;
   localparam logic [KEY_W-1:0] KEY_MUL       = 5'd21;
   localparam logic [KEY_W-1:0] KEY_DIV       = 5'd22;
   localparam logic [KEY_W-1:0] KEY_ON        = 5'd30;
   localparam logic [KEY_W-1:0] KEY_EQ        = 5'd31;

   // Stored operator codes
   localparam logic [OPER_W-1:0] OPER_NONE = 3'd0;
   localparam logic [OPER_W-1:0] OPER_ADD  = 3'd1;
   localparam logic [OPER_W-1:0] OPER_SUB  = 3'd2;
   localparam logic [OPER_W-1:0] OPER_MUL  = 3'd3;
   localparam logic [OPER_W-1:0] OPER_DIV  = 3'd4;
   localparam logic [OPER_W-1:0] OPER_EQ   = 3'd5;

   // Display status codes
   localparam logic [STATUS_W-1:0] STAT_OFF    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FIRST  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_SECOND = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_RESULT = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_DIVZ   = 3'd4;

   // Source of the displayed value
   typedef enum logic [1:0] {
      SHOW_ZERO   = 2'd0,
      SHOW_FIRST  = 2'd1,
      SHOW_SECOND = 2'd2,
      SHOW_RESULT = 2'd3
   } show_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                acc_first;
      logic                acc_second;
      logic                clr_all;
      logic                clr_second;
      logic                oper_wr;
      logic [OPER_W-1:0]   oper_val;
      logic                calc_start;
      logic                calc_step;
      logic                res_wr;
      logic                out_load;
      show_sel_type        out_sel;
      logic [STATUS_W-1:0] out_status;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic full;
      logic div_zero;
      logic last_step;
      logic oper_mul;
      logic oper_div;
   } dp_sts_type;

endpackage

// ===== sv/kffc_ctrl.sv =====
module kffc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [kffc_pkg::KEY_W-1:0]    key,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output kffc_pkg::dp_cmd_type          cmd,
   input  kffc_pkg::dp_sts_type          sts
);
   import kffc_pkg::*;

   typedef enum logic [4:0] {
      ST_OFF    = 5'b00001,
      ST_FIRST  = 5'b00010,
      ST_SECOND = 5'b00100,
      ST_CALC   = 5'b01000,
      ST_DONE   = 5'b10000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          valid_ff, valid_in;
   logic          out_free;
   logic          accept;
   logic          is_digit;
   logic          is_oper;
   logic          is_command;
   logic [OPER_W-1:0] key_oper;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = out_free &&
                       (state_ff == ST_OFF || state_ff == ST_FIRST || state_ff == ST_SECOND);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   // Decode the key
   always_comb begin
      is_digit   = key <= KEY_DIGIT_MAX;
      is_oper    = key inside {[KEY_ADD:KEY_DIV]};
      is_command = is_oper || key == KEY_ON || key == KEY_EQ;
      key_oper   = (key == KEY_EQ) ? OPER_EQ : OPER_W'(key - KEY_ADD) + OPER_ADD;
   end

   // Sequence each item
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_sel = SHOW_ZERO;
      case (state_ff)
         ST_OFF: begin
            if (accept) begin
               cmd.out_load = 1'b1;
               if (key == KEY_ON) begin
                  cmd.clr_all    = 1'b1;
                  cmd.out_status = STAT_FIRST;
                  state_in       = ST_FIRST;
               end else begin
                  cmd.out_status = STAT_OFF;
               end
            end
         end
         ST_FIRST: begin
            if (accept) begin
               cmd.out_load = 1'b1;
               if (is_digit) begin
                  cmd.acc_first = 1'b1;
                  cmd.out_sel   = SHOW_FIRST;
                  if (sts.full) begin
                     cmd.clr_second = 1'b1;
                     cmd.out_status = STAT_SECOND;
                     state_in       = ST_SECOND;
                  end else begin
                     cmd.out_status = STAT_FIRST;
                  end
               end else if (key == KEY_ON) begin
                  cmd.oper_wr    = 1'b1;
                  cmd.oper_val   = OPER_NONE;
                  cmd.out_status = STAT_OFF;
                  state_in       = ST_OFF;
               end else if (is_command) begin
                  cmd.oper_wr    = 1'b1;
                  cmd.oper_val   = key_oper;
                  cmd.clr_second = 1'b1;
                  cmd.out_status = STAT_SECOND;
                  state_in       = ST_SECOND;
               end else begin
                  cmd.out_sel    = SHOW_FIRST;
                  cmd.out_status = STAT_FIRST;
               end
            end
         end
         ST_SECOND: begin
            if (accept) begin
               cmd.acc_second = is_digit;
               if ((is_digit && sts.full) || is_command) begin
                  // Operand complete: compute now, flag divide by zero, or start the shared unit
                  if (sts.oper_mul || (sts.oper_div && !sts.div_zero)) begin
                     cmd.calc_start = 1'b1;
                     state_in       = ST_CALC;
                  end else if (sts.oper_div) begin
                     cmd.out_load   = 1'b1;
                     cmd.out_status = STAT_DIVZ;
                     cmd.clr_all    = 1'b1;
                     state_in       = ST_FIRST;
                  end else begin
                     cmd.out_load   = 1'b1;
                     cmd.out_sel    = SHOW_RESULT;
                     cmd.out_status = STAT_RESULT;
                     cmd.res_wr     = 1'b1;
                     cmd.clr_all    = 1'b1;
                     state_in       = ST_FIRST;
                  end
               end else begin
                  cmd.out_load   = 1'b1;
                  cmd.out_sel    = SHOW_SECOND;
                  cmd.out_status = STAT_SECOND;
               end
            end
         end
         ST_CALC: begin
            cmd.calc_step = 1'b1;
            if (sts.last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_sel    = SHOW_RESULT;
               cmd.out_status = STAT_RESULT;
               cmd.res_wr     = 1'b1;
               cmd.clr_all    = 1'b1;
               state_in       = ST_FIRST;
            end
         end
         default: begin
            state_in = ST_OFF;
         end
      endcase
   end

   // Hold the result item until taken
   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_OFF;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== sv/kffc_dpath.sv =====
module kffc_dpath #(
   parameter int MAX_DIGITS = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [kffc_pkg::KEY_W-1:0]     key,
   input  kffc_pkg::dp_cmd_type           cmd,
   output kffc_pkg::dp_sts_type           sts,
   output logic [kffc_pkg::RES_W-1:0]     shown_value,
   output logic [kffc_pkg::STATUS_W-1:0]  status,
   output logic [kffc_pkg::OPER_W-1:0]    chosen_operator
);
   import kffc_pkg::*;

   localparam int OPW = $clog2(10 ** MAX_DIGITS);
   localparam int CW  = $clog2(MAX_DIGITS + 1);
   localparam int SW  = $clog2(OPW);

   // Append one decimal digit
   function automatic logic [OPW-1:0] push_digit(input logic [OPW-1:0] x,
                                                 input logic [KEY_W-1:0] k);
      logic [OPW+3:0] t;
      t = {x, 3'b000} + {2'b00, x, 1'b0} + (OPW+4)'(k);
      return t[OPW-1:0];
   endfunction

   logic [CW-1:0]     count_ff, count_in;
   logic [OPW-1:0]    first_ff, first_in, first_acc;
   logic [OPW-1:0]    second_ff, second_in, second_acc;
   logic [OPER_W-1:0] oper_ff, oper_in;
   logic [RES_W-1:0]  last_ff, last_in;
   logic [RES_W-1:0]  acc_ff, acc_in;
   logic [RES_W-1:0]  mcand_ff, mcand_in;
   logic [OPW-1:0]    work_ff, work_in;
   logic [SW-1:0]     step_ff, step_in;
   logic [RES_W-1:0]  shown_ff, shown_in;
   logic [STATUS_W-1:0] status_ff;
   logic [OPER_W-1:0] chosen_ff;
   logic [OPW:0]      div_shift;
   logic [OPW:0]      div_diff;
   logic              div_ge;
   logic [RES_W-1:0]  a_wide, b_wide;
   logic [RES_W-1:0]  res_value;

   // Operand entry
   assign first_acc  = cmd.acc_first  ? push_digit(first_ff, key)  : first_ff;
   assign second_acc = cmd.acc_second ? push_digit(second_ff, key) : second_ff;

   always_comb begin
      count_in  = count_ff;
      first_in  = first_acc;
      second_in = second_acc;
      if (cmd.acc_first || cmd.acc_second) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.clr_second) begin
         count_in  = '0;
         second_in = '0;
      end
      if (cmd.clr_all) begin
         count_in  = '0;
         first_in  = '0;
         second_in = '0;
      end
   end

   assign oper_in = cmd.oper_wr ? cmd.oper_val : oper_ff;

   // Operands widened to the result width, and the result select
   assign a_wide = RES_W'(first_ff);
   assign b_wide = RES_W'(second_acc);

   always_comb begin
      case (oper_ff)
         OPER_ADD: res_value = a_wide + b_wide;
         OPER_SUB: res_value = a_wide - b_wide;
         OPER_MUL: res_value = acc_ff;
         OPER_DIV: res_value = RES_W'(work_ff);
         default:  res_value = last_ff;
      endcase
   end

   assign last_in = cmd.res_wr ? res_value : last_ff;

   // Shared shift-add multiplier and restoring divider, one bit a cycle
   assign div_shift = {acc_ff[OPW-1:0], work_ff[OPW-1]};
   assign div_diff  = div_shift - {1'b0, mcand_ff[OPW-1:0]};
   assign div_ge    = !div_diff[OPW];

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      work_in  = work_ff;
      step_in  = step_ff;
      if (cmd.calc_start) begin
         acc_in  = '0;
         step_in = '0;
         if (oper_ff == OPER_DIV) begin
            work_in  = first_ff;
            mcand_in = b_wide;
         end else begin
            work_in  = second_acc;
            mcand_in = a_wide;
         end
      end else if (cmd.calc_step) begin
         step_in = step_ff + SW'(1);
         if (oper_ff == OPER_DIV) begin
            acc_in  = RES_W'(div_ge ? div_diff[OPW-1:0] : div_shift[OPW-1:0]);
            work_in = {work_ff[OPW-2:0], div_ge};
         end else begin
            if (work_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = {mcand_ff[RES_W-2:0], 1'b0};
            work_in  = {1'b0, work_ff[OPW-1:1]};
         end
      end
   end

   // Pick the displayed value
   always_comb begin
      case (cmd.out_sel)
         SHOW_FIRST:  shown_in = RES_W'(first_acc);
         SHOW_SECOND: shown_in = RES_W'(second_acc);
         SHOW_RESULT: shown_in = res_value;
         default:     shown_in = '0;
      endcase
   end

   always_comb begin
      sts.full      = count_ff == CW'(MAX_DIGITS - 1);
      sts.div_zero  = second_acc == '0;
      sts.last_step = step_ff == SW'(OPW - 1);
      sts.oper_mul  = oper_ff == OPER_MUL;
      sts.oper_div  = oper_ff == OPER_DIV;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         oper_ff   <= OPER_NONE;
         last_ff   <= '0;
      end else begin
         count_ff  <= count_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         oper_ff   <= oper_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      work_ff  <= work_in;
      step_ff  <= step_in;
      if (cmd.out_load) begin
         shown_ff  <= shown_in;
         status_ff <= cmd.out_status;
         chosen_ff <= oper_in;
      end
   end

   assign shown_value     = shown_ff;
   assign status          = status_ff;
   assign chosen_operator = chosen_ff;

endmodule

// ===== sv/keypad_four_function_calculator.sv =====
// Channel  Direction  Payload (low bit first)
// req      in         tdata[7:0]:  key[4:0], zero fill
// rsp      out        tdata[47:0]: shown_value[34:0], status[37:35], chosen_operator[40:38]
//
// A digit, command or ignored key gives its result item in the cycle after it is accepted.
// Multiply and divide run on a shared unit that retires one operand bit per cycle (OPW = bits of
// the largest operand, 17); the result item follows once the output register is free.
// Reset is synchronous; it turns the calculator off and clears operands and operator.
// A new key is taken only while no result waits in the output register or it is being taken.
module keypad_four_function_calculator #(
   parameter int MAX_DIGITS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // key[4:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // shown_value[34:0], status[37:35], chosen_operator[40:38]
);
   import kffc_pkg::*;

   dp_cmd_type          cmd;
   dp_sts_type          sts;
   logic [KEY_W-1:0]    key;
   logic [RES_W-1:0]    shown_value;
   logic [STATUS_W-1:0] status;
   logic [OPER_W-1:0]   chosen_operator;

   assign key = req_tdata[KEY_W-1:0];

   kffc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .key        (key),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   kffc_dpath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .key             (key),
      .cmd             (cmd),
      .sts             (sts),
      .shown_value     (shown_value),
      .status          (status),
      .chosen_operator (chosen_operator)
   );

   // Pack the result item
   assign rsp_tdata = {7'b0, chosen_operator, status, shown_value};

   // A key is never taken while an untaken result would be overwritten
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!rsp_tvalid || rsp_tready))
      else $error("key accepted over a waiting result");

   // Off and divide-by-zero items show zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (status == STAT_OFF || status == STAT_DIVZ)) |-> (shown_value == '0))
      else $error("nonzero display with off or error status");

   // Status is a defined code
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (status <= STAT_DIVZ))
      else $error("undefined status code");

   // Hold a waiting result item unchanged until it is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("waiting result item changed or dropped");

endmodule

// ===== sim/keypad_four_function_calculator_test.sv =====
module keypad_four_function_calculator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import kffc_pkg::*;

   localparam int MAX_DIGITS     = 5;
   localparam int RANDOM_CHUNKS  = 12;
   localparam int CHUNK_KEYS     = 75;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef enum logic [1:0] {
      CALC_OFF,
      CALC_FIRST,
      CALC_SECOND
   } calc_phase_type;

   typedef struct packed {
      logic signed [RES_W-1:0] shown;
      logic [STATUS_W-1:0]     status;
      logic [OPER_W-1:0]       oper;
   } display_type;

   // Track calculator state per accepted key and hold the displays still owed
   class calc_scoreboard;
      calc_phase_type    mode;
      int unsigned       digits;
      logic [16:0]       opnd_a;
      logic [16:0]       opnd_b;
      logic [OPER_W-1:0] oper;
      logic [RES_W-1:0]  last_value;
      display_type       display_q[$];
      int                mismatches;

      function new();
         mode       = CALC_OFF;
         digits     = 0;
         opnd_a     = '0;
         opnd_b     = '0;
         oper       = OPER_NONE;
         last_value = '0;
         mismatches = 0;
      endfunction

      function bit is_off();
         return mode == CALC_OFF;
      endfunction

      function int outstanding();
         return display_q.size();
      endfunction

      function void add_display(logic [RES_W-1:0] value, logic [STATUS_W-1:0] st);
         display_type d;
         d.shown  = value;
         d.status = st;
         d.oper   = oper;
         display_q.push_back(d);
      endfunction

      function void clear_operands();
         digits = 0;
         opnd_a = '0;
         opnd_b = '0;
      endfunction

      function void note_key(logic [KEY_W-1:0] k);
         bit          is_digit;
         bit          is_cmd;
         bit          done;
         logic [63:0] wide_a;
         logic [63:0] wide_b;
         logic [63:0] wide_r;
         is_digit = (k <= KEY_DIGIT_MAX);
         is_cmd   = (k >= KEY_ADD && k <= KEY_DIV) || k == KEY_ON || k == KEY_EQ;
         case (mode)
            CALC_OFF: begin
               // only AC/ON wakes the calculator; the operator survives
               if (k == KEY_ON) begin
                  clear_operands();
                  mode = CALC_FIRST;
                  add_display('0, STAT_FIRST);
               end else begin
                  add_display('0, STAT_OFF);
               end
            end
            CALC_FIRST: begin
               if (is_digit) begin
                  opnd_a = opnd_a * 17'd10 + 17'(k);
                  digits++;
                  // full first operand moves on and keeps the old operator
                  if (digits >= MAX_DIGITS) begin
                     digits = 0;
                     opnd_b = '0;
                     mode   = CALC_SECOND;
                     add_display(RES_W'(opnd_a), STAT_SECOND);
                  end else begin
                     add_display(RES_W'(opnd_a), STAT_FIRST);
                  end
               end else if (k == KEY_ON) begin
                  mode = CALC_OFF;
                  oper = OPER_NONE;
                  add_display('0, STAT_OFF);
               end else if (is_cmd) begin
                  oper   = (k == KEY_EQ) ? OPER_EQ : OPER_W'(k - KEY_ADD) + OPER_ADD;
                  digits = 0;
                  opnd_b = '0;
                  mode   = CALC_SECOND;
                  add_display('0, STAT_SECOND);
               end else begin
                  add_display(RES_W'(opnd_a), STAT_FIRST);
               end
            end
            default: begin
               done = 1'b0;
               if (is_digit) begin
                  opnd_b = opnd_b * 17'd10 + 17'(k);
                  digits++;
                  done = (digits >= MAX_DIGITS);
               end else if (is_cmd) begin
                  done = 1'b1;
               end
               if (!done) begin
                  add_display(RES_W'(opnd_b), STAT_SECOND);
               end else begin
                  // compute at full width, wrap to the display width
                  wide_a = 64'(opnd_a);
                  wide_b = 64'(opnd_b);
                  if (oper == OPER_DIV && opnd_b == '0) begin
                     add_display('0, STAT_DIVZ);
                  end else begin
                     case (oper)
                        OPER_ADD: wide_r = wide_a + wide_b;
                        OPER_SUB: wide_r = wide_a - wide_b;
                        OPER_MUL: wide_r = wide_a * wide_b;
                        OPER_DIV: wide_r = wide_a / wide_b;
                        default:  wide_r = 64'(last_value);
                     endcase
                     last_value = wide_r[RES_W-1:0];
                     add_display(last_value, STAT_RESULT);
                  end
                  clear_operands();
                  mode = CALC_FIRST;
               end
            end
         endcase
      endfunction

      function void check_result(logic [47:0] data);
         display_type want;
         display_type got;
         got.shown  = data[34:0];
         got.status = data[37:35];
         got.oper   = data[40:38];
         if (display_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item, expected none, actual shown %0d status %0d oper %0d",
                     $time, got.shown, got.status, got.oper);
            return;
         end
         want = display_q.pop_front();
         if (got.shown !== want.shown) begin
            mismatches++;
            $display("%0t: shown_value expected %0d actual %0d", $time, want.shown, got.shown);
         end
         if (got.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         end
         if (got.oper !== want.oper) begin
            mismatches++;
            $display("%0t: chosen_operator expected %0d actual %0d", $time, want.oper,
                     got.oper);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // key[4:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // shown_value[34:0], status[37:35], chosen_operator[40:38]

   calc_scoreboard sb;
   int             idle_pct  = 0;
   int             stall_pct = 0;
   int             chunk;

   keypad_four_function_calculator #(
      .MAX_DIGITS(MAX_DIGITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Check results before noting the key taken on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_key(req_tdata[KEY_W-1:0]);
      end
   end

   // Drive one key, with random idle cycles ahead of it
   task automatic send_key(input logic [KEY_W-1:0] k);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, k};
      do @(posedge clock); while (!req_tready);
   endtask

   // Mostly well-formed entry: digits, operators, equals; some AC and noise
   function automatic logic [KEY_W-1:0] next_random_key();
      int unsigned roll;
      int unsigned pick;
      roll = $urandom_range(99);
      if (sb.is_off() && roll < 70) return KEY_ON;
      if (roll < 55) return KEY_W'($urandom_range(9));
      if (roll < 75) return KEY_ADD + KEY_W'($urandom_range(3));
      if (roll < 83) return KEY_EQ;
      if (roll < 86) return KEY_ON;
      if (roll < 94) begin
         // ignored codes 10-18 and 23-29
         pick = $urandom_range(15);
         return (pick < 9) ? KEY_W'(10 + pick) : KEY_W'(14 + pick);
      end
      return KEY_W'($urandom_range(31));
   endfunction

   // End the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // off: ignored digit, then power on
      send_key(5'd5);
      send_key(KEY_ON);
      // zero times zero leaves multiply stored
      send_key(KEY_MUL);
      send_key(KEY_EQ);
      // full operands give the largest product
      repeat (5) send_key(5'd9);
      repeat (5) send_key(5'd9);
      // divide by zero
      send_key(KEY_DIV);
      send_key(KEY_EQ);
      // most negative difference
      send_key(KEY_SUB);
      repeat (5) send_key(5'd9);
      // add, then equals as operator repeats the last result
      send_key(5'd1);
      send_key(KEY_ADD);
      send_key(5'd2);
      send_key(KEY_EQ);
      send_key(KEY_EQ);
      send_key(5'd27);
      send_key(KEY_ADD);
      // AC in first operand turns it off
      send_key(KEY_ON);
      send_key(KEY_EQ);

      // random keys, rotating through the idle and stall mixes
      for (chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         case (chunk % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 68; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 68; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         repeat (CHUNK_KEYS) send_key(next_random_key());
      end
      req_tvalid <= 1'b0;

      // drain remaining displays, then watch for strays
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/kffc_pkg.sv
sv/kffc_ctrl.sv
sv/kffc_dpath.sv
sv/keypad_four_function_calculator.sv
sim/keypad_four_function_calculator_test.sv
